>>> rtl/transport_section_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the section filter checker
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_SECTION_FILTER_CORE_MACROS_SVH
`define TRANSPORT_SECTION_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// Section filter package
// Request and result payloads, entry layout, controller state and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tsf_pkg;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_SECTION = 2'd0,
        REQ_PACKET  = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_WRITE   = 2'd3
    } t_req_type;

    // One incoming request.
    typedef struct packed {
        t_req_type   req_type;
        logic [3:0]  tuner;
        logic [12:0] pid;
        logic [12:0] data_length;
        logic [63:0] byte_pattern;
        logic [31:0] time_value;
        logic [3:0]  entry_index;
        logic        entry_enable;
        logic [7:0]  entry_table_id;
        logic        entry_match_by_mask;
        logic [63:0] entry_mask;
    } t_tsf_req;

    // One result.
    typedef struct packed {
        logic [15:0] match_bits;
        logic [15:0] expired_bits;
    } t_tsf_rsp;

    // Entry fields held in the entry RAM (timeout is appended above these).
    typedef struct packed {
        logic [3:0]  tuner;
        logic [12:0] pid;
        logic [7:0]  table_id;
        logic        by_mask;
        logic [63:0] filter;
        logic [63:0] mask;
    } t_tsf_entry;

    localparam int ENTRY_W     = $bits(t_tsf_entry);
    localparam int MAP_W       = 16;
    localparam int MAX_ENTRIES = 16;
    localparam int TIME_W      = 32;
    localparam int LANES       = 8;

    // Section byte offset carried by each lane of the byte pattern.
    localparam logic [12:0] LANE_OFFSET [LANES] = '{
        13'd0, 13'd3, 13'd4, 13'd5, 13'd6, 13'd7, 13'd8, 13'd9
    };

    localparam logic [12:0] MIN_DATA_LEN = 13'd3;
    localparam logic [12:0] MIN_MASK_LEN = 13'd8;

    // Configuration register map (index is byte address divided by four).
    localparam logic REG_IDX_FILTER_EN = 1'b0;
    localparam int   APB_ADDR_W        = 3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_tsf_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;
        logic write_entry;
        logic walk_en;
        logic load_out;
    } t_tsf_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_is_write;
        logic last_addr;
        logic out_free;
    } t_tsf_sts;

endpackage

>>> rtl/tsf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tsf_regs.sv
// ----------------------------------------------------------------------------
// Section filter configuration registers
// APB-style slave holding the filtering enable bit.
// ----------------------------------------------------------------------------
module tsf_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic                            o_filter_en
);
    import tsf_pkg::*;

    logic r_filter_en;
    logic hit;

    // Register index is the word address; byte lanes within a word are ignored.
    assign hit = (paddr[APB_ADDR_W-1] == REG_IDX_FILTER_EN);

    // Write at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b0;
        end else if (psel && penable && pwrite && hit) begin
            r_filter_en <= pwdata[0];
        end
    end

    // Read back and a slave that never waits.
    assign prdata      = hit ? {31'd0, r_filter_en} : 32'd0;
    assign pready      = 1'b1;
    assign o_filter_en = r_filter_en;

endmodule

>>> rtl/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// Section filter controller
// Sequences each request: accept, entry write or table walk, result handoff.
// ----------------------------------------------------------------------------
module tsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tsf_pkg::t_tsf_sts i_sts,
    output tsf_pkg::t_tsf_cmd o_cmd
);
    import tsf_pkg::*;

    t_tsf_state r_state;
    t_tsf_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = i_sts.in_is_write ? ST_WRITE : ST_WALK;
                end
            end
            ST_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state = ST_FINISH;
            end
            ST_WALK: begin
                o_cmd.walk_en = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last entry's read data is evaluated in this cycle.
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tsf_dp.sv
// ----------------------------------------------------------------------------
// Section filter datapath
// Request register, entry RAM, enable bits, per-entry match logic,
// result bitmaps and the output register.
// ----------------------------------------------------------------------------
module tsf_dp #(
    parameter int FILTER_ENTRIES = 16,
    parameter int TIME_BITS      = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_filter_en,
    input  tsf_pkg::t_tsf_req i_in_req,
    input  tsf_pkg::t_tsf_cmd i_cmd,
    output tsf_pkg::t_tsf_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tsf_pkg::t_tsf_rsp o_out_rsp
);
    import tsf_pkg::*;

    // Only entries reachable by a 4-bit write index are stored.
    localparam int NE     = (FILTER_ENTRIES < MAX_ENTRIES) ? FILTER_ENTRIES : MAX_ENTRIES;
    localparam int CW     = (NE > 1) ? $clog2(NE) : 1;
    localparam int TW     = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam bit INF_OK = (TIME_BITS <= TIME_W);
    localparam int RAM_W  = ENTRY_W + TW;

    t_tsf_req          r_req;
    logic [CW-1:0]     r_addr;
    logic              r_rd_vld;
    logic [CW-1:0]     r_rd_idx;
    logic              r_enable [NE];
    logic [MAP_W-1:0]  r_match;
    logic [MAP_W-1:0]  r_expired;
    logic              r_out_valid;
    t_tsf_rsp          r_rsp;

    logic [RAM_W-1:0]  ram_rdata;
    logic [RAM_W-1:0]  ram_wdata;
    logic              ram_we;
    logic [CW-1:0]     waddr;
    t_tsf_entry        wr_ent;
    t_tsf_entry        rd_ent;
    logic [TW-1:0]     rd_tmo;
    logic [TW-1:0]     now;
    logic              en;
    logic              inf;
    logic              gate;
    logic              pid_eq;
    logic              cand;
    logic              mask_ok;
    logic              sec_hit;
    logic              pkt_hit;
    logic              exp_hit;
    logic [MAP_W-1:0]  idx_bit;
    logic              out_free;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_req;
        end
    end

    assign now = r_req.time_value[TW-1:0];

    // Entry write: timeout stored masked to the time width.
    assign wr_ent.tuner    = r_req.tuner;
    assign wr_ent.pid      = r_req.pid;
    assign wr_ent.table_id = r_req.entry_table_id;
    assign wr_ent.by_mask  = r_req.entry_match_by_mask;
    assign wr_ent.filter   = r_req.byte_pattern;
    assign wr_ent.mask     = r_req.entry_mask;
    assign ram_wdata       = {now, wr_ent};
    assign waddr           = r_req.entry_index[CW-1:0];
    assign ram_we          = i_cmd.write_entry
                             && (32'(r_req.entry_index) < 32'(FILTER_ENTRIES));

    tsf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Walk address and read-data tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.walk_en;
            if (i_cmd.load_req) begin
                r_addr <= '0;
            end else if (i_cmd.walk_en) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    // Per-entry evaluation of the entry read in the previous cycle.
    assign rd_ent  = t_tsf_entry'(ram_rdata[ENTRY_W-1:0]);
    assign rd_tmo  = ram_rdata[RAM_W-1:ENTRY_W];
    assign en      = r_enable[r_rd_idx];
    assign inf     = INF_OK && (rd_tmo == {TW{1'b1}});
    assign gate    = i_filter_en && (r_req.data_length >= MIN_DATA_LEN);
    assign pid_eq  = (rd_ent.pid == r_req.pid);
    assign cand    = en && pid_eq && (rd_ent.tuner == r_req.tuner)
                     && ((now < rd_tmo) || inf);

    // Masked byte match; lanes beyond the section length are skipped.
    always_comb begin
        mask_ok = (r_req.data_length >= MIN_MASK_LEN);
        for (int i = 0; i < LANES; i++) begin
            if ((LANE_OFFSET[i] < r_req.data_length)
                && (((r_req.byte_pattern[8*i +: 8] ^ rd_ent.filter[8*i +: 8])
                     & rd_ent.mask[8*i +: 8]) != 8'd0)) begin
                mask_ok = 1'b0;
            end
        end
    end

    assign sec_hit = gate && cand
                     && (rd_ent.by_mask ? mask_ok
                                        : (rd_ent.table_id == r_req.byte_pattern[7:0]));
    // Packets take only the first enabled entry with the PID.
    assign pkt_hit = gate && en && pid_eq && (r_match == '0);
    assign exp_hit = en && !inf && (now >= rd_tmo);
    assign idx_bit = MAP_W'(1) << r_rd_idx;

    // Result bitmaps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_match   <= '0;
            r_expired <= '0;
        end else if (r_rd_vld) begin
            case (r_req.req_type)
                REQ_SECTION: begin
                    if (sec_hit) begin
                        r_match <= r_match | idx_bit;
                    end
                end
                REQ_PACKET: begin
                    if (pkt_hit) begin
                        r_match <= r_match | idx_bit;
                    end
                end
                REQ_TIMEOUT: begin
                    if (exp_hit) begin
                        r_expired <= r_expired | idx_bit;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Enable bits: loaded on write, cleared by an expired timeout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NE; e++) begin
                r_enable[e] <= 1'b0;
            end
        end else if (ram_we) begin
            r_enable[waddr] <= r_req.entry_enable;
        end else if (r_rd_vld && (r_req.req_type == REQ_TIMEOUT) && exp_hit) begin
            r_enable[r_rd_idx] <= 1'b0;
        end
    end

    // Output register.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp.match_bits   <= r_match;
            r_rsp.expired_bits <= r_expired;
        end
    end

    // Status to the controller.
    assign o_sts.in_is_write = (i_in_req.req_type == REQ_WRITE);
    assign o_sts.last_addr   = (r_addr == CW'(NE - 1));
    assign o_sts.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

>>> rtl/transport_section_filter_core.sv
// ----------------------------------------------------------------------------
// Transport-stream section filter core
// Matches sections and TS packets against a table of filter entries, reports
// expired entries and loads entries, one request at a time.
// ----------------------------------------------------------------------------
// A write request passes through the write and finish states. Section,
// packet and timeout-check requests walk the entry table through the single
// read port of the entry RAM, one entry per cycle, then pass through the
// drain and finish states. The next request is accepted once the result has
// moved into the output register, which holds it while the consumer stalls.
// Entries beyond 16 cannot be written and are not stored. The filtering
// enable register gates section and packet matching only.
module transport_section_filter_core #(
    parameter int FILTER_ENTRIES = 16,
    parameter int TIME_BITS      = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tsf_pkg::t_tsf_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tsf_pkg::t_tsf_rsp               o_out_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tsf_pkg::*;

    t_tsf_cmd cmd;
    t_tsf_sts sts;
    logic     filter_en;

    // Configuration registers.
    tsf_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_filter_en (filter_en)
    );

    // Request sequencer.
    tsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Entry table and match logic.
    tsf_dp #(
        .FILTER_ENTRIES (FILTER_ENTRIES),
        .TIME_BITS      (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_filter_en (filter_en),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

>>> rtl/tsf_checker.sv
// ----------------------------------------------------------------------------
// Section filter port checker
// Watches the top-level ports of the filter core and flags rule breaks.
// ----------------------------------------------------------------------------
`include "transport_section_filter_core_macros.svh"

module tsf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input tsf_pkg::t_tsf_rsp o_out_rsp
);

    // A stalled result stays offered.
    `TSF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // A stalled result does not change.
    `TSF_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_rsp), "result changed while stalled")

    // A result carries matches or expirations, never both.
    `TSF_ASSERT_IMP(a_rsp_kind, i_clk, i_rst_n, o_out_valid, (o_out_rsp.match_bits == 16'd0) || (o_out_rsp.expired_bits == 16'd0), "result has both match and expired bits")

    // The core works on one request at a time.
    `TSF_ASSERT_NXT(a_one_request, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second request taken while busy")

endmodule

bind transport_section_filter_core tsf_checker u_tsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);
